### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ATTE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("atte: same-cycle check failed");

// Next-cycle implication.
`define ATTE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("atte: next-cycle check failed");

`endif

### sv/atte_pkg.sv
// ----------------------------------------------------------------------------
// atte_pkg
// Types, codes and constants shared by the terminal engine modules.
// ----------------------------------------------------------------------------
package atte_pkg;

    localparam int MAX_COLS   = 128;
    localparam int MAX_ROWS   = 64;
    localparam int TAB_SPACES = 8;

    localparam int COL_W      = 7;
    localparam int ROW_W      = 6;
    localparam int COLS_CFG_W = 8;
    localparam int ROWS_CFG_W = 7;
    localparam int CFG_W      = 8;
    localparam int REP_W      = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;

    localparam logic [REP_W-1:0] TAB_LAST = REP_W'(TAB_SPACES - 1);

    // Configuration register indexes.
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_CURSOR  = 2'd0;
    localparam logic [1:0] KIND_CELL    = 2'd1;
    localparam logic [1:0] KIND_CLR_ROW = 2'd2;
    localparam logic [1:0] KIND_CLR_SCR = 2'd3;

    // Commands from the parser to the executor.
    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_BS    = 3'd1;
    localparam logic [2:0] OP_CR    = 3'd2;
    localparam logic [2:0] OP_LF    = 3'd3;
    localparam logic [2:0] OP_CLS   = 3'd4;

    // Parser modes.
    localparam logic [1:0] MODE_REGULAR = 2'd0;
    localparam logic [1:0] MODE_ESC     = 2'd1;
    localparam logic [1:0] MODE_BRACKET = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_HT     = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_J      = 8'h4A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_M      = 8'h6D;

    // Attribute handling.
    localparam logic [7:0] ATTR_BRIGHT  = 8'h01;
    localparam logic [7:0] COLOUR_MASK  = 8'hF0;
    localparam logic [7:0] SGR_BRIGHT   = 8'd1;
    localparam logic [7:0] SGR_WHITE    = 8'd37;
    localparam logic [7:0] SGR_COL_LO   = 8'd31;
    localparam logic [7:0] SGR_COL_HI   = 8'd36;
    localparam logic [7:0] SGR_COL_BASE = 8'd30;
    localparam logic [7:0] CLS_PARAM    = 8'd2;
    localparam logic [7:0] PARAM_MAX    = 8'd255;

    typedef struct packed {
        logic [2:0]       op;
        logic [7:0]       sym;
        logic [7:0]       attrs;
        logic [REP_W-1:0] rep_last;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [ROW_W-1:0] row_addr;
        logic [COL_W-1:0] col_addr;
        logic [7:0]       symbol;
        logic [7:0]       cell_attrs;
        logic [COL_W-1:0] cursor_col;
        logic [ROW_W-1:0] cursor_row;
        logic [ROW_W-1:0] top_row;
        logic             last;
    } res_t;

    // Effective screen size, already limited to the legal range.
    typedef struct packed {
        logic [COLS_CFG_W-1:0] cols;
        logic [ROWS_CFG_W-1:0] rows;
    } screen_cfg_t;

endpackage

### sv/atte_front.sv
// ----------------------------------------------------------------------------
// atte_front
// Escape parser: tracks parse mode, parameter and attributes, and turns
// accepted bytes into commands for the executor.
// ----------------------------------------------------------------------------
module atte_front
    import atte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] char_in,
    output logic       cmd_push,
    output cmd_t       cmd
);

    logic [1:0]  mode_reg, mode_next;
    logic [7:0]  param_reg, param_next;
    logic [7:0]  attrs_reg, attrs_next;
    logic [11:0] param_prod;
    logic        is_digit;

    assign is_digit   = (char_in >= CH_0) && (char_in <= CH_9);
    // param * 10 + digit, computed as two shifts and adds.
    assign param_prod = ({4'b0, param_reg} << 3) + ({4'b0, param_reg} << 1)
                      + {4'b0, char_in - CH_0};

    always_comb
    begin
        mode_next  = mode_reg;
        param_next = param_reg;
        attrs_next = attrs_reg;
        cmd_push   = 1'b0;
        cmd        = '{op: OP_WRITE, sym: char_in, attrs: attrs_reg, rep_last: '0};
        if (accept)
        begin
            unique case (mode_reg)
                MODE_ESC:
                begin
                    mode_next = (char_in == CH_LBRACK) ? MODE_BRACKET : MODE_REGULAR;
                end
                MODE_BRACKET:
                begin
                    if (is_digit)
                    begin
                        param_next = (param_prod > {4'b0, PARAM_MAX}) ? PARAM_MAX
                                                                      : param_prod[7:0];
                    end
                    else
                    begin
                        mode_next = MODE_REGULAR;
                        if (char_in == CH_M)
                        begin
                            if (param_reg == SGR_BRIGHT || param_reg == SGR_WHITE)
                                attrs_next = attrs_reg | ATTR_BRIGHT;
                            else if (param_reg >= SGR_COL_LO && param_reg <= SGR_COL_HI)
                                attrs_next = (attrs_reg & ~COLOUR_MASK)
                                           | ((param_reg - SGR_COL_BASE) << 4);
                            else
                                attrs_next = '0;
                        end
                        else if (char_in == CH_J && param_reg == CLS_PARAM)
                        begin
                            cmd_push = 1'b1;
                            cmd.op   = OP_CLS;
                        end
                    end
                end
                default:
                begin
                    // The unused mode code behaves as regular.
                    mode_next = MODE_REGULAR;
                    unique case (char_in)
                        CH_ESC:
                        begin
                            param_next = '0;
                            mode_next  = MODE_ESC;
                        end
                        CH_BS:
                        begin
                            cmd_push = 1'b1;
                            cmd.op   = OP_BS;
                        end
                        CH_CR:
                        begin
                            cmd_push = 1'b1;
                            cmd.op   = OP_CR;
                        end
                        CH_LF:
                        begin
                            cmd_push = 1'b1;
                            cmd.op   = OP_LF;
                        end
                        CH_HT:
                        begin
                            cmd_push     = 1'b1;
                            cmd.sym      = CH_SPACE;
                            cmd.rep_last = TAB_LAST;
                        end
                        default:
                        begin
                            cmd_push = 1'b1;
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_REGULAR;
            param_reg <= '0;
            attrs_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            param_reg <= param_next;
            attrs_reg <= attrs_next;
        end
    end

endmodule

### sv/atte_cmd_queue.sv
// ----------------------------------------------------------------------------
// atte_cmd_queue
// Two-entry command queue between the parser and the executor.
// ----------------------------------------------------------------------------
module atte_cmd_queue
    import atte_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t din,
    input  logic pop,
    output logic full,
    output logic valid,
    output cmd_t dout
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign full   = (count_reg == 2'd2);
    assign valid  = (count_reg != 2'd0);
    assign dout   = mem_reg[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (!push && do_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

endmodule

### sv/atte_back.sv
// ----------------------------------------------------------------------------
// atte_back
// Executor: owns the cursor and top offset, carries out one command step a
// cycle while the output queue has room, and holds the results in that
// two-entry output queue.
module atte_back
    import atte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  screen_cfg_t cfg,
    input  logic        byte_taken,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    input  logic        res_pop,
    output logic        res_empty,
    output res_t        res
);

    logic [COL_W-1:0] col_reg, col_next, col_c;
    logic [ROW_W-1:0] row_reg, row_next, row_c;
    logic [ROW_W-1:0] top_reg, top_next, top_c;
    logic [REP_W-1:0] rep_reg, rep_next;
    logic             clr_pend_reg, clr_pend_next;
    logic [ROW_W-1:0] clr_row_reg, clr_row_next;
    logic             clr_last_reg, clr_last_next;

    logic [COLS_CFG_W-1:0] cols_m1;
    logic [ROWS_CFG_W-1:0] rows_m1;
    logic [ROWS_CFG_W-1:0] top_sum, addr_sum;
    logic [ROW_W-1:0]      top_wrap, cell_addr;
    logic                  col_at_end, row_at_bottom, final_w;

    res_t       q_reg [2];
    logic       q_wr_reg, q_rd_reg;
    logic [1:0] q_count_reg, q_count_next;
    logic       can_emit, emit, q_pop;
    res_t       res_new;

    // A shrunk screen limits the stored cursor and offset when a step starts.
    assign cols_m1 = cfg.cols - 1'b1;
    assign rows_m1 = cfg.rows - 1'b1;
    assign col_c   = ({1'b0, col_reg} > cols_m1) ? cols_m1[COL_W-1:0] : col_reg;
    assign row_c   = ({1'b0, row_reg} > rows_m1) ? rows_m1[ROW_W-1:0] : row_reg;
    assign top_c   = ({1'b0, top_reg} >= cfg.rows) ? '0 : top_reg;

    assign col_at_end    = ({1'b0, col_c} == cols_m1);
    assign row_at_bottom = ({1'b0, row_c} == rows_m1);

    assign top_sum  = {1'b0, top_c} + 7'd1;
    assign top_wrap = (top_sum == cfg.rows) ? '0 : top_sum[ROW_W-1:0];

    // Both terms are below the row count, so one subtract folds the ring.
    assign addr_sum  = {1'b0, top_c} + {1'b0, row_c};
    assign cell_addr = (addr_sum >= cfg.rows) ? ROW_W'(addr_sum - cfg.rows)
                                              : addr_sum[ROW_W-1:0];

    assign final_w  = (rep_reg == cmd.rep_last);
    assign can_emit = (q_count_reg != 2'd2);

    always_comb
    begin
        // Every taken byte limits the state, also one that makes no command.
        col_next      = byte_taken ? col_c : col_reg;
        row_next      = byte_taken ? row_c : row_reg;
        top_next      = byte_taken ? top_c : top_reg;
        rep_next      = rep_reg;
        clr_pend_next = clr_pend_reg;
        clr_row_next  = clr_row_reg;
        clr_last_next = clr_last_reg;
        emit          = 1'b0;
        cmd_pop       = 1'b0;
        res_new       = '0;
        if (can_emit)
        begin
            if (clr_pend_reg)
            begin
                emit             = 1'b1;
                res_new.kind     = KIND_CLR_ROW;
                res_new.row_addr = clr_row_reg;
                res_new.last     = clr_last_reg;
                clr_pend_next    = 1'b0;
                cmd_pop          = clr_last_reg;
            end
            else if (cmd_valid)
            begin
                emit     = 1'b1;
                col_next = col_c;
                row_next = row_c;
                top_next = top_c;
                unique case (cmd.op)
                    OP_WRITE:
                    begin
                        res_new.kind       = KIND_CELL;
                        res_new.row_addr   = cell_addr;
                        res_new.col_addr   = col_c;
                        res_new.symbol     = cmd.sym;
                        res_new.cell_attrs = cmd.attrs;
                        res_new.last       = final_w;
                        cmd_pop            = final_w;
                        rep_next           = final_w ? '0 : rep_reg + 1'b1;
                        if (col_at_end)
                        begin
                            col_next = '0;
                            if (row_at_bottom)
                            begin
                                top_next      = top_wrap;
                                clr_pend_next = 1'b1;
                                clr_row_next  = top_c;
                                clr_last_next = final_w;
                                res_new.last  = 1'b0;
                                cmd_pop       = 1'b0;
                            end
                            else
                            begin
                                row_next = row_c + 1'b1;
                            end
                        end
                        else
                        begin
                            col_next = col_c + 1'b1;
                        end
                    end
                    OP_BS:
                    begin
                        res_new.kind = KIND_CURSOR;
                        res_new.last = 1'b1;
                        cmd_pop      = 1'b1;
                        if (col_c != '0)
                        begin
                            col_next = col_c - 1'b1;
                        end
                        else if (row_c != '0)
                        begin
                            row_next = row_c - 1'b1;
                            col_next = cols_m1[COL_W-1:0];
                        end
                    end
                    OP_CR:
                    begin
                        res_new.kind = KIND_CURSOR;
                        res_new.last = 1'b1;
                        cmd_pop      = 1'b1;
                        col_next     = '0;
                    end
                    OP_LF:
                    begin
                        res_new.last = 1'b1;
                        cmd_pop      = 1'b1;
                        if (row_at_bottom)
                        begin
                            res_new.kind     = KIND_CLR_ROW;
                            res_new.row_addr = top_c;
                            top_next         = top_wrap;
                        end
                        else
                        begin
                            res_new.kind = KIND_CURSOR;
                            row_next     = row_c + 1'b1;
                        end
                    end
                    OP_CLS:
                    begin
                        res_new.kind = KIND_CLR_SCR;
                        res_new.last = 1'b1;
                        cmd_pop      = 1'b1;
                        col_next     = '0;
                        row_next     = '0;
                        top_next     = '0;
                    end
                    default:
                    begin
                        res_new.kind = KIND_CURSOR;
                        res_new.last = 1'b1;
                        cmd_pop      = 1'b1;
                    end
                endcase
            end
        end
        res_new.cursor_col = col_next;
        res_new.cursor_row = row_next;
        res_new.top_row    = top_next;
    end

    // Output queue.
    assign res_empty = (q_count_reg == 2'd0);
    assign res       = q_reg[q_rd_reg];
    assign q_pop     = res_pop && !res_empty;

    always_comb
    begin
        q_count_next = q_count_reg;
        if (emit && !q_pop)
            q_count_next = q_count_reg + 2'd1;
        else if (!emit && q_pop)
            q_count_next = q_count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            top_reg      <= '0;
            rep_reg      <= '0;
            clr_pend_reg <= 1'b0;
            clr_last_reg <= 1'b0;
            q_wr_reg     <= 1'b0;
            q_rd_reg     <= 1'b0;
            q_count_reg  <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            top_reg      <= top_next;
            rep_reg      <= rep_next;
            clr_pend_reg <= clr_pend_next;
            clr_last_reg <= clr_last_next;
            q_count_reg  <= q_count_next;
            if (emit)
                q_wr_reg <= ~q_wr_reg;
            if (q_pop)
                q_rd_reg <= ~q_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        clr_row_reg <= clr_row_next;
        if (emit)
            q_reg[q_wr_reg] <= res_new;
    end

endmodule

### sv/ansi_text_terminal_engine.sv
// ----------------------------------------------------------------------------
// ansi_text_terminal_engine
// Terminal byte interpreter that drives an external character store.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake               Beat
//   --------  ---------  ----------------------  ---------------------------
//   input     in         push / full             char_in
//   result    out        empty / pop             kind .. last, nine fields
//   config    in         cfg_we (no wait)        cfg_index, cfg_wdata
//
// A byte is taken every cycle while the command queue has room. The executor
// emits one result beat per cycle while the output queue has room; a plain
// byte costs one beat, a tab eight, a write that scrolls one more; the executor
// sets the sustained rate. A result beat passes the command and output queues,
// both registered. All control state clears on rst_n; screen size returns to
// 80 by 25. Either side may stall on its own: the two-entry queues absorb it.
//
// The design splits into a parser (escape modes, parameter, attributes), a
// two-entry command queue, and an executor that owns the cursor and the ring
// offset of the top row and buffers its results in a two-entry queue.
// Attributes travel with each write command, so an attribute change that is
// parsed while older writes are still queued does not reach those writes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ansi_text_terminal_engine
    import atte_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Byte input.
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            char_in,
    // Configuration writes.
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // Results.
    output logic                  empty,
    input  logic                  pop,
    output logic [1:0]            kind,
    output logic [ROW_W-1:0]      row_addr,
    output logic [COL_W-1:0]      col_addr,
    output logic [7:0]            symbol,
    output logic [7:0]            cell_attrs,
    output logic [COL_W-1:0]      cursor_col,
    output logic [ROW_W-1:0]      cursor_row,
    output logic [ROW_W-1:0]      top_row,
    output logic                  last
);

    // The stored screen size is the effective one: zero reads as one and anything
    // above the maximum is held there; rows use only the low seven data bits.
    screen_cfg_t cfg_reg;
    logic [ROWS_CFG_W-1:0] rows_wdata;

    logic accept;
    logic front_push;
    cmd_t front_cmd;
    logic cmd_valid;
    logic cmd_pop;
    cmd_t head_cmd;
    res_t res;

    assign accept     = push && !full;
    assign rows_wdata = cfg_wdata[ROWS_CFG_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cols <= COLS_CFG_W'(80);
            cfg_reg.rows <= ROWS_CFG_W'(25);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COLS:
                begin
                    if (cfg_wdata == '0)
                        cfg_reg.cols <= COLS_CFG_W'(1);
                    else if (cfg_wdata > COLS_CFG_W'(MAX_COLS))
                        cfg_reg.cols <= COLS_CFG_W'(MAX_COLS);
                    else
                        cfg_reg.cols <= cfg_wdata;
                end
                default:
                begin
                    if (rows_wdata == '0)
                        cfg_reg.rows <= ROWS_CFG_W'(1);
                    else if (rows_wdata > ROWS_CFG_W'(MAX_ROWS))
                        cfg_reg.rows <= ROWS_CFG_W'(MAX_ROWS);
                    else
                        cfg_reg.rows <= rows_wdata;
                end
            endcase
        end
    end

    atte_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .char_in  (char_in),
        .cmd_push (front_push),
        .cmd      (front_cmd)
    );

    atte_cmd_queue u_cmd_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .din   (front_cmd),
        .pop   (cmd_pop),
        .full  (full),
        .valid (cmd_valid),
        .dout  (head_cmd)
    );

    atte_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .byte_taken (accept),
        .cmd_valid  (cmd_valid),
        .cmd        (head_cmd),
        .cmd_pop    (cmd_pop),
        .res_pop    (pop),
        .res_empty  (empty),
        .res        (res)
    );

    assign kind       = res.kind;
    assign row_addr   = res.row_addr;
    assign col_addr   = res.col_addr;
    assign symbol     = res.symbol;
    assign cell_attrs = res.cell_attrs;
    assign cursor_col = res.cursor_col;
    assign cursor_row = res.cursor_row;
    assign top_row    = res.top_row;
    assign last       = res.last;

    // The parser only hands over commands for bytes that were taken, and a
    // command handed over is at the queue head, or behind it, in the cycle after.
    `ATTE_ASSERT_IMP(a_push_only_on_accept, front_push, accept)
    `ATTE_ASSERT_NXT(a_cmd_lands, front_push, cmd_valid)
    // Fields that carry no meaning for a kind read as zero.
    `ATTE_ASSERT_IMP(a_non_cell_zero, !empty && kind != KIND_CELL,
        col_addr == '0 && symbol == '0 && cell_attrs == '0)
    // A screen clear homes the cursor and the ring offset.
    `ATTE_ASSERT_IMP(a_clear_screen_home, !empty && kind == KIND_CLR_SCR,
        cursor_col == '0 && cursor_row == '0 && top_row == '0 && row_addr == '0)

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Terminal engine testbench
// Streams terminal bytes (plain text, controls, escape sequences both
// well-formed and broken) into the engine across several screen sizes, and
// checks every result beat against an independent model of the cursor,
// scroll ring and attribute parser.
// ----------------------------------------------------------------------------
import atte_pkg::*;

class terminal_scoreboard;

    localparam int unsigned MAX_REPORTS = 10;

    // Screen size registers as written, before range limiting.
    logic [7:0]  cols_reg;
    logic [6:0]  rows_reg;

    // Parser and cursor state.
    logic [1:0]  mode;
    int unsigned param;
    logic [7:0]  attrs;
    int unsigned col;
    int unsigned row;
    int unsigned top;

    res_t        due_q[$];
    int unsigned mismatches;

    function new();
        cols_reg   = 8'd80;
        rows_reg   = 7'd25;
        mode       = MODE_REGULAR;
        param      = 0;
        attrs      = '0;
        col        = 0;
        row        = 0;
        top        = 0;
        mismatches = 0;
    endfunction

    function void write_reg(logic idx, logic [7:0] data);
        if (idx == REG_COLS)
            cols_reg = data;
        else
            rows_reg = data[6:0];
    endfunction

    function int unsigned screen_cols();
        if (cols_reg == 0)
            return 1;
        if (cols_reg > MAX_COLS)
            return MAX_COLS;
        return cols_reg;
    endfunction

    function int unsigned screen_rows();
        if (rows_reg == 0)
            return 1;
        if (rows_reg > MAX_ROWS)
            return MAX_ROWS;
        return rows_reg;
    endfunction

    // Every beat carries the cursor and top row as they stand when it is made.
    function void emit(logic [1:0] k, int unsigned ra, int unsigned ca,
                       logic [7:0] s, logic [7:0] a);
        res_t r;
        r.kind       = k;
        r.row_addr   = ROW_W'(ra);
        r.col_addr   = COL_W'(ca);
        r.symbol     = s;
        r.cell_attrs = a;
        r.cursor_col = COL_W'(col);
        r.cursor_row = ROW_W'(row);
        r.top_row    = ROW_W'(top);
        r.last       = 1'b0;
        due_q.push_back(r);
    endfunction

    // Moves down one row. Past the bottom the ring offset advances and the
    // physical row that was on top becomes the new, cleared bottom row.
    function bit line_feed(output int unsigned cleared);
        int unsigned rows;
        rows    = screen_rows();
        cleared = 0;
        row++;
        if (row >= rows)
        begin
            row     = rows - 1;
            cleared = top;
            top     = (top + 1) % rows;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function void put_cell(logic [7:0] c);
        int unsigned addr;
        int unsigned at_col;
        int unsigned cleared;
        bit          scrolled;
        addr     = (top + row) % screen_rows();
        at_col   = col;
        cleared  = 0;
        scrolled = 1'b0;
        col++;
        if (col >= screen_cols())
        begin
            col      = 0;
            scrolled = line_feed(cleared);
        end
        emit(KIND_CELL, addr, at_col, c, attrs);
        if (scrolled)
            emit(KIND_CLR_ROW, cleared, 0, 8'h00, 8'h00);
    endfunction

    // Works out the result beats that one accepted byte causes.
    function void take_byte(logic [7:0] c);
        int unsigned cols;
        int unsigned rows;
        int unsigned cleared;
        int unsigned first;
        res_t        r;
        cols    = screen_cols();
        rows    = screen_rows();
        cleared = 0;
        first   = due_q.size();

        // A screen that shrank since the last byte pulls the state inside it.
        if (col >= cols)
            col = cols - 1;
        if (row >= rows)
            row = rows - 1;
        if (top >= rows)
            top = 0;

        if (mode == MODE_ESC)
        begin
            mode = (c == CH_LBRACK) ? MODE_BRACKET : MODE_REGULAR;
            return;
        end

        if (mode == MODE_BRACKET)
        begin
            if (c >= CH_0 && c <= CH_9)
            begin
                param = param * 10 + (c - CH_0);
                if (param > PARAM_MAX)
                    param = PARAM_MAX;
                return;
            end
            mode = MODE_REGULAR;
            if (c == CH_M)
            begin
                if (param == SGR_BRIGHT || param == SGR_WHITE)
                    attrs = attrs | ATTR_BRIGHT;
                else if (param >= SGR_COL_LO && param <= SGR_COL_HI)
                    attrs = (attrs & ~COLOUR_MASK) | 8'((param - SGR_COL_BASE) << 4);
                else
                    attrs = '0;
            end
            else if (c == CH_J && param == CLS_PARAM)
            begin
                col = 0;
                row = 0;
                top = 0;
                emit(KIND_CLR_SCR, 0, 0, 8'h00, 8'h00);
            end
        end
        else
        begin
            mode = MODE_REGULAR;
            case (c)
                CH_ESC:
                begin
                    param = 0;
                    mode  = MODE_ESC;
                end
                CH_BS:
                begin
                    if (col > 0)
                        col--;
                    else if (row > 0)
                    begin
                        row--;
                        col = cols - 1;
                    end
                    emit(KIND_CURSOR, 0, 0, 8'h00, 8'h00);
                end
                CH_CR:
                begin
                    col = 0;
                    emit(KIND_CURSOR, 0, 0, 8'h00, 8'h00);
                end
                CH_LF:
                begin
                    if (line_feed(cleared))
                        emit(KIND_CLR_ROW, cleared, 0, 8'h00, 8'h00);
                    else
                        emit(KIND_CURSOR, 0, 0, 8'h00, 8'h00);
                end
                CH_HT:
                begin
                    repeat (TAB_SPACES)
                        put_cell(CH_SPACE);
                end
                default:
                    put_cell(c);
            endcase
        end

        if (due_q.size() > first)
        begin
            r      = due_q.pop_back();
            r.last = 1'b1;
            due_q.push_back(r);
        end
    endfunction

    function void report(string why, res_t want, res_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s: exp/got kind %0d/%0d row %0d/%0d col %0d/%0d",
                     $time, why, want.kind, got.kind, want.row_addr, got.row_addr,
                     want.col_addr, got.col_addr,
                     "\n    sym %h/%h attr %h/%h cursor %0d,%0d/%0d,%0d",
                     want.symbol, got.symbol, want.cell_attrs, got.cell_attrs,
                     want.cursor_col, want.cursor_row, got.cursor_col, got.cursor_row,
                     " top %0d/%0d last %0d/%0d",
                     want.top_row, got.top_row, want.last, got.last);
    endfunction

    function void check_result(res_t got);
        res_t want;
        if (due_q.size() == 0)
        begin
            report("result beat with nothing pending", '0, got);
            return;
        end
        want = due_q.pop_front();
        if (got.kind !== want.kind || got.row_addr !== want.row_addr
            || got.col_addr !== want.col_addr || got.symbol !== want.symbol
            || got.cell_attrs !== want.cell_attrs || got.cursor_col !== want.cursor_col
            || got.cursor_row !== want.cursor_row || got.top_row !== want.top_row
            || got.last !== want.last)
            report("result beat mismatch", want, got);
    endfunction

endclass

module testbench;

    // This margin covers bytes that leave no result behind, such as the tail of an escape sequence.
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES = 6;
    localparam int TOKENS_PER_PHASE = 22;

    // The opening sequence, run on a 4 x 3 screen so that wrapping and
    // scrolling come up within a handful of bytes.
    localparam logic [7:0] OPENING [24] = '{
        CH_BS,                          // backspace at the top left stays put
        8'h00, 8'hFF, 8'h7F, 8'h80,     // extreme bytes fill the row and wrap
        CH_BS,                          // backspace climbs to the row above
        CH_CR, CH_LF, CH_LF, CH_LF,     // the last line feed scrolls
        CH_HT,                          // a tab wraps twice and scrolls twice
        CH_ESC, CH_LBRACK, "3", "1", CH_M,
        "A",                            // written in red
        CH_ESC, CH_LBRACK, "2", CH_J,   // clear screen and home
        CH_ESC, "x",                    // broken escape, dropped
        "B"
    };

    typedef enum logic [1:0] {POP_ALWAYS, POP_HALF, POP_RARE, POP_WINDOW} pop_style_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [7:0]            char_in = 8'h00;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = REG_COLS;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [1:0]            kind;
    logic [ROW_W-1:0]      row_addr;
    logic [COL_W-1:0]      col_addr;
    logic [7:0]            symbol;
    logic [7:0]            cell_attrs;
    logic [COL_W-1:0]      cursor_col;
    logic [ROW_W-1:0]      cursor_row;
    logic [ROW_W-1:0]      top_row;
    logic                  last;

    terminal_scoreboard    board;
    pop_style_t            pop_style = POP_ALWAYS;
    logic [15:0]           pop_cycle = '0;

    ansi_text_terminal_engine dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // The receiver picks a new stall style when the counter's low seven bits are
    // zero: always ready, coin flip, mostly stalled, or ready while bits [3:0] < 10.
    always @(posedge clk)
    begin
        pop_cycle <= pop_cycle + 1'b1;
        if (pop_cycle[6:0] == 7'd0)
            pop_style <= pop_style_t'($urandom_range(0, 3));
        case (pop_style)
            POP_ALWAYS: pop <= 1'b1;
            POP_HALF:   pop <= 1'($urandom_range(0, 1));
            POP_RARE:   pop <= ($urandom_range(0, 3) == 0);
            default:    pop <= (pop_cycle[3:0] < 4'd10);
        endcase
    end

    // Everything is sampled at the clock edge, before any of this edge's
    // nonblocking updates land, so the scoreboard sees what the engine sees.
    // An input beat is noted before the output beat of the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                board.write_reg(cfg_index, cfg_wdata);
            if (push && !full)
                board.take_byte(char_in);
            if (pop && !empty)
                board.check_result(res_t'({kind, row_addr, col_addr, symbol, cell_attrs,
                                            cursor_col, cursor_row, top_row, last}));
        end
    end

    // Holds one byte on the input until the engine takes it. A following
    // call keeps push high, so bytes can stream back to back.
    task automatic send_byte(input logic [7:0] b);
        push    <= 1'b1;
        char_in <= b;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        push <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    // Stops sending and waits for every pending result beat to come out.
    task automatic settle_output();
        push <= 1'b0;
        @(posedge clk);
        while (board.due_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Writes both size registers on consecutive edges; only called while idle.
    task automatic set_screen(input logic [7:0] cols, input logic [7:0] rows);
        cfg_we    <= 1'b1;
        cfg_index <= REG_COLS;
        cfg_wdata <= cols;
        @(posedge clk);
        cfg_index <= REG_ROWS;
        cfg_wdata <= rows;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // ESC [ <decimal value> <final byte>, with the digits left out on request.
    task automatic send_csi(input int unsigned value, input bit with_digits,
                            input logic [7:0] final_byte);
        string digits;
        digits = $sformatf("%0d", value);
        send_byte(CH_ESC);
        send_byte(CH_LBRACK);
        if (with_digits)
            for (int k = 0; k < digits.len(); k++)
                send_byte(digits[k]);
        send_byte(final_byte);
    endtask

    // One random unit of terminal traffic. Mostly text and well-formed
    // sequences; about one in seven units is noise or a broken escape.
    task automatic send_random_token();
        int unsigned pick;
        int unsigned value;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            send_byte(8'($urandom_range(32, 126)));
        else if (pick < 48)
            send_byte(8'($urandom_range(0, 255)));
        else if (pick < 54)
            send_byte(CH_CR);
        else if (pick < 60)
            send_byte(CH_LF);
        else if (pick < 65)
            send_byte(CH_BS);
        else if (pick < 69)
            send_byte(CH_HT);
        else if (pick < 81)
        begin
            // Attribute sequences: bright, white, each color, reset, any
            // small value, and larger values, most long enough to saturate the parameter.
            case ($urandom_range(0, 5))
                0:       value = SGR_BRIGHT;
                1:       value = SGR_WHITE;
                2:       value = $urandom_range(SGR_COL_LO, SGR_COL_HI);
                3:       value = 0;
                4:       value = $urandom_range(0, 99);
                default: value = $urandom_range(100, 99999);
            endcase
            send_csi(value, $urandom_range(0, 7) != 0, CH_M);
        end
        else if (pick < 86)
        begin
            value = ($urandom_range(0, 2) != 0) ? CLS_PARAM : $urandom_range(0, 20);
            send_csi(value, $urandom_range(0, 7) != 0, CH_J);
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    send_byte(CH_ESC);
                    send_byte(8'($urandom_range(0, 255)));
                end
                1:       send_csi(0, 1'b0, 8'($urandom_range(0, 255)));
                default: send_csi($urandom_range(0, 999), 1'b1, 8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial
    begin
        logic [7:0]  cols_plan [PHASES];
        logic [7:0]  rows_plan [PHASES];
        int unsigned tokens;
        int unsigned burst;
        int unsigned gap;

        board = new();

        // Screen sizes per phase: the widest and tallest (written as values
        // beyond the maximum), zero registers that read as a 1 x 1 screen
        // and squeeze the state left by the large one, a single full-width
        // row, a single column, and two random sizes.
        cols_plan = '{8'd255, 8'd0, 8'd128, 8'd1,
                      8'($urandom_range(2, 12)), 8'($urandom_range(1, 255))};
        rows_plan = '{8'hFF, 8'd0, 8'd1, 8'd64,
                      8'($urandom_range(2, 6)), 8'($urandom_range(0, 255))};

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_screen(8'd4, 8'd3);
        foreach (OPENING[i])
            send_byte(OPENING[i]);
        settle_output();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_screen(cols_plan[ph], rows_plan[ph]);

            // On the largest screen, tabs reach the last column and line
            // feeds run past the bottom row and scroll the ring.
            if (ph == 0)
            begin
                repeat (17)
                    send_byte(CH_HT);
                repeat (70)
                    send_byte(CH_LF);
            end

            tokens = 0;
            while (tokens < TOKENS_PER_PHASE)
            begin
                burst = $urandom_range(1, 24);
                repeat (burst)
                    send_random_token();
                tokens += burst;

                // Between bursts: now and then wait until the engine has
                // drained, often no gap at all, otherwise a short pause.
                gap = $urandom_range(0, 15);
                if (gap == 0)
                    settle_output();
                else if (gap >= 6)
                    pause_sender($urandom_range(1, 8));
            end
            settle_output();
        end

        if (board.mismatches == 0 && board.due_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
